[rtl/oaht_pkg.sv]
// Shared types, constants and codes of the open addressing hash table.
package oaht_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int KEY_W = 32;
   localparam int VAL_W = 64;
   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W = 6;
   localparam int COUNT_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(48);

   localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE = 2'd1,
      MARK_TOMB = 2'd2
   } mark_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic wr_en;
      logic wr_value_en;
      logic [IDX_W-1:0] wr_idx;
      mark_type wr_mark;
      logic [KEY_W-1:0] wr_key;
      logic [VAL_W-1:0] wr_value;
   } mem_req_type;

   typedef struct packed {
      mark_type mark;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } mem_rsp_type;

endpackage

[rtl/oaht_store.sv]
// Slot memories for keys, marks and values, with per-slot valid bits cleared at reset.
module oaht_store (
   input logic clock,
   input logic reset,
   input oaht_pkg::mem_req_type mem_req,
   output oaht_pkg::mem_rsp_type mem_rsp
);
   import oaht_pkg::*;

   mark_type mark_mem [CAPACITY];
   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [VAL_W-1:0] val_mem [CAPACITY];
   logic [CAPACITY-1:0] vld_ff;
   logic [CAPACITY-1:0] vld_in;

   mark_type rd_mark_ff;
   logic rd_vld_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic [VAL_W-1:0] rd_val_ff;

   always_comb begin
      vld_in = vld_ff;
      if (mem_req.wr_en) begin
         vld_in[mem_req.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mark_mem[mem_req.wr_idx] <= mem_req.wr_mark;
         key_mem[mem_req.wr_idx] <= mem_req.wr_key;
      end
      if (mem_req.rd_en) begin
         rd_mark_ff <= mark_mem[mem_req.rd_idx];
         rd_vld_ff <= vld_ff[mem_req.rd_idx];
         rd_key_ff <= key_mem[mem_req.rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en && mem_req.wr_value_en) begin
         val_mem[mem_req.wr_idx] <= mem_req.wr_value;
      end
      if (mem_req.rd_en) begin
         rd_val_ff <= val_mem[mem_req.rd_idx];
      end
   end

   always_comb begin
      mem_rsp.mark = rd_vld_ff ? rd_mark_ff : MARK_EMPTY;
      mem_rsp.key = rd_key_ff;
      mem_rsp.value = rd_val_ff;
   end

endmodule

[rtl/oaht_ctrl.sv]
// Probe sequencer: walks the slots, decides the outcome and writes back.
module oaht_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [oaht_pkg::FUNC_W-1:0] req_func,
   input logic [oaht_pkg::KEY_W-1:0] req_key_id,
   input logic [oaht_pkg::KEY_W-1:0] req_key_hash,
   input logic [oaht_pkg::VAL_W-1:0] req_value_in,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [oaht_pkg::STATUS_W-1:0] rsp_status,
   output logic rsp_is_new_key,
   output logic [oaht_pkg::VAL_W-1:0] rsp_value_out,
   input logic csr_valid,
   output logic csr_ready,
   input logic [oaht_pkg::LIMIT_W-1:0] csr_max_used_slots,
   output oaht_pkg::mem_req_type mem_req,
   input oaht_pkg::mem_rsp_type mem_rsp
);
   import oaht_pkg::*;

   state_type state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic tomb_seen_ff, tomb_seen_in;
   logic [IDX_W-1:0] tomb_idx_ff, tomb_idx_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic empty_ff, empty_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic [VAL_W-1:0] hit_val_ff, hit_val_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic is_new_ff, is_new_in;
   logic [VAL_W-1:0] value_out_ff, value_out_in;
   logic fits;
   logic out_free;
   logic [IDX_W-1:0] idx_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_is_new_key = is_new_ff;
   assign rsp_value_out = value_out_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_next = idx_ff + IDX_W'(1);
   assign fits = ({1'b0, used_ff} + 8'd1) <= {2'b00, limit_ff};

   always_comb begin
      state_in = state_ff;
      func_in = func_ff;
      key_in = key_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_idx_in = tomb_idx_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      empty_in = empty_ff;
      empty_idx_in = empty_idx_ff;
      hit_val_in = hit_val_ff;
      used_in = used_ff;
      limit_in = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in = status_ff;
      is_new_in = is_new_ff;
      value_out_in = value_out_ff;
      mem_req = '0;
      mem_req.wr_mark = MARK_LIVE;
      mem_req.wr_key = key_ff;
      mem_req.wr_value = val_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_max_used_slots;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               key_in = req_key_id;
               val_in = req_value_in;
               idx_in = req_key_hash[IDX_W-1:0];
               cnt_in = '0;
               tomb_seen_in = 1'b0;
               hit_in = 1'b0;
               empty_in = 1'b0;
               mem_req.rd_en = 1'b1;
               mem_req.rd_idx = req_key_hash[IDX_W-1:0];
               if (req_func == FUNC_GET || req_func == FUNC_SET || req_func == FUNC_DEL) begin
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PROBE: begin
            priority if (mem_rsp.mark == MARK_EMPTY) begin
               empty_in = 1'b1;
               empty_idx_in = idx_ff;
               state_in = ST_DONE;
            end else if (mem_rsp.mark == MARK_LIVE && mem_rsp.key == key_ff) begin
               hit_in = 1'b1;
               hit_idx_in = idx_ff;
               hit_val_in = mem_rsp.value;
               state_in = ST_DONE;
            end else begin
               if (mem_rsp.mark == MARK_TOMB && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_idx_in = idx_ff;
               end
               if (cnt_ff == IDX_W'(CAPACITY - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
                  idx_in = idx_next;
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_idx = idx_next;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in = STATUS_NOT_FOUND;
               is_new_in = 1'b0;
               value_out_in = '0;
               state_in = ST_IDLE;
               priority if (func_ff == FUNC_GET) begin
                  if (hit_ff) begin
                     status_in = STATUS_OK;
                     value_out_in = hit_val_ff;
                  end
               end else if (func_ff == FUNC_DEL) begin
                  if (hit_ff) begin
                     status_in = STATUS_OK;
                     mem_req.wr_en = 1'b1;
                     mem_req.wr_idx = hit_idx_ff;
                     mem_req.wr_mark = MARK_TOMB;
                  end
               end else if (func_ff == FUNC_SET) begin
                  mem_req.wr_value_en = 1'b1;
                  priority if (hit_ff) begin
                     status_in = STATUS_OK;
                     mem_req.wr_en = 1'b1;
                     mem_req.wr_idx = hit_idx_ff;
                  end else if (tomb_seen_ff) begin
                     status_in = STATUS_OK;
                     is_new_in = 1'b1;
                     mem_req.wr_en = 1'b1;
                     mem_req.wr_idx = tomb_idx_ff;
                  end else if (empty_ff && fits) begin
                     status_in = STATUS_OK;
                     is_new_in = 1'b1;
                     used_in = used_ff + COUNT_W'(1);
                     mem_req.wr_en = 1'b1;
                     mem_req.wr_idx = empty_idx_ff;
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         limit_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      key_ff <= key_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      tomb_seen_ff <= tomb_seen_in;
      tomb_idx_ff <= tomb_idx_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      empty_ff <= empty_in;
      empty_idx_ff <= empty_idx_in;
      hit_val_ff <= hit_val_in;
      status_ff <= status_in;
      is_new_ff <= is_new_in;
      value_out_ff <= value_out_in;
   end

endmodule

[rtl/open_address_hash_table.sv]
// Top level of the open addressing hash table with linear probing and tombstones.
//
// Items arrive on the req_ channel (get, set or delete with key id, hash and value)
// and each gives exactly one result item on the rsp_ channel (status, new-key flag,
// value). Both channels use valid/ready; the csr_ channel writes the slot limit and
// is taken only while no item is in progress.
// One item is worked on at a time. After acceptance the sequencer reads one slot per
// cycle from the slot memories, starting at the home slot given by the low hash bits,
// until it finds the key or an empty slot, or has examined every slot. An item is
// accepted, probed over k slots where k is the number of slots examined (1 to 64),
// then decided and written back; the result is shown in the following cycle.
// A new item is accepted only after the previous one has been decided and written back.
// An unknown operation skips the probe and gives a not-found result.
// The result sits in an output register; while the receiver stalls, the next item is
// accepted and probed, and only the write-back waits for the register to drain.
// Reset clears the valid bit of every slot at once, so the table is empty in the
// next cycle, the used count is zero and the slot limit returns to 48.
module open_address_hash_table (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [oaht_pkg::FUNC_W-1:0] req_func,
   input logic [oaht_pkg::KEY_W-1:0] req_key_id,
   input logic [oaht_pkg::KEY_W-1:0] req_key_hash,
   input logic [oaht_pkg::VAL_W-1:0] req_value_in,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [oaht_pkg::STATUS_W-1:0] rsp_status,
   output logic rsp_is_new_key,
   output logic [oaht_pkg::VAL_W-1:0] rsp_value_out,
   input logic csr_valid,
   output logic csr_ready,
   input logic [oaht_pkg::LIMIT_W-1:0] csr_max_used_slots
);
   import oaht_pkg::*;

   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   oaht_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_key_id(req_key_id),
      .req_key_hash(req_key_hash),
      .req_value_in(req_value_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_is_new_key(rsp_is_new_key),
      .rsp_value_out(rsp_value_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_used_slots(csr_max_used_slots),
      .mem_req(mem_req),
      .mem_rsp(mem_rsp)
   );

   oaht_store u_store (
      .clock(clock),
      .reset(reset),
      .mem_req(mem_req),
      .mem_rsp(mem_rsp)
   );

endmodule
